@@ rtl/tsrgb_pkg.sv @@
`timescale 1ns / 1ps

package tsrgb_pkg;

    // Number of touch pads and LED channels (green, red, blue).
    localparam int NUM_PADS = 3;
    localparam int PAD_W    = 2;

    localparam logic [PAD_W-1:0] FIRST_PAD = PAD_W'(0);
    localparam logic [PAD_W-1:0] LAST_PAD  = PAD_W'(NUM_PADS - 1);

    localparam int SAMPLE_W = 16;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_TICK   = 1'b1
    } cmd_t;

    // The code 2'b11 is never produced and is treated as no fade.
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } fade_dir_t;

    typedef struct packed {
        fade_dir_t dir;
        logic      on;
    } chan_ctl_t;

endpackage

@@ rtl/tsrgb_fade_chan.sv @@
`timescale 1ns / 1ps

// One fade step of a single LED channel: step the duty by its direction,
// then clamp it into the range from one to one below full scale.
module tsrgb_fade_chan #(
    parameter int DUTY_WIDTH = 16
) (
    input  logic [DUTY_WIDTH-1:0] duty_in,
    input  tsrgb_pkg::chan_ctl_t  ctl_in,
    output logic [DUTY_WIDTH-1:0] duty_out,
    output tsrgb_pkg::chan_ctl_t  ctl_out
);

    localparam logic [DUTY_WIDTH-1:0] DUTY_TOP   = {DUTY_WIDTH{1'b1}};
    localparam logic [DUTY_WIDTH-1:0] DUTY_CEIL  = {{(DUTY_WIDTH-1){1'b1}}, 1'b0};
    localparam logic [DUTY_WIDTH-1:0] DUTY_FLOOR = DUTY_WIDTH'(1);
    localparam logic [DUTY_WIDTH-1:0] DUTY_ZERO  = '0;

    logic [DUTY_WIDTH-1:0] stepped;

    always_comb begin
        case (ctl_in.dir)
            tsrgb_pkg::DIR_UP: begin
                stepped = (duty_in == DUTY_TOP) ? DUTY_TOP : duty_in + DUTY_WIDTH'(1);
            end
            tsrgb_pkg::DIR_DOWN: begin
                // Falling from zero holds at zero rather than wrapping.
                stepped = (duty_in == DUTY_ZERO) ? DUTY_ZERO : duty_in - DUTY_WIDTH'(1);
            end
            default: begin
                stepped = duty_in;
            end
        endcase
    end

    always_comb begin
        duty_out = stepped;
        ctl_out  = ctl_in;
        if (stepped == DUTY_TOP) begin
            duty_out    = DUTY_CEIL;
            ctl_out.on  = 1'b1;
            ctl_out.dir = tsrgb_pkg::DIR_NONE;
        end else if (stepped == DUTY_ZERO) begin
            duty_out    = DUTY_FLOOR;
            ctl_out.on  = 1'b0;
            ctl_out.dir = tsrgb_pkg::DIR_NONE;
        end
    end

endmodule

@@ rtl/touch_scan_rgb_fader.sv @@
`timescale 1ns / 1ps

// Touch scan and RGB fader. Pad readings (cmd 0) are credited round robin to
// pads 0, 1, 2; a nonzero reading at or below the touch threshold marks its
// pad touched, and a zero reading only advances the pad pointer. Fade ticks
// (cmd 1) pick fade directions from the touched pads, the highest touched
// pad winning, and then step the green, red and blue duties by one, clamped
// to 1 .. 2^DUTY_WIDTH-2. Every input beat yields exactly one result beat
// holding the flags, the next pad and the three duties after that beat.
// The block takes one beat per clock while the output is not stalled: an
// input register and a result register bracket a single pass of logic,
// whose longest path is the direction select followed by one DUTY_WIDTH-bit
// increment and compare per channel. An accepted beat waits in the input
// register until the result register is free, then moves on into it.
// The threshold register should be written only while no beat is in flight.
module touch_scan_rgb_fader #(
    parameter int DUTY_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [15:0]           cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [15:0]           s_sample,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_touch_flags,
    output logic [1:0]            m_scanned_pad,
    output logic [DUTY_WIDTH-1:0] m_green_duty,
    output logic [DUTY_WIDTH-1:0] m_red_duty,
    output logic [DUTY_WIDTH-1:0] m_blue_duty,
    output logic [2:0]            m_on_flags
);

    localparam int NP = tsrgb_pkg::NUM_PADS;

    // ------------------------------------------------------------------
    // Configuration: the threshold register is always ready for a beat.
    // ------------------------------------------------------------------
    logic [tsrgb_pkg::SAMPLE_W-1:0] threshold_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            threshold_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Input register. It drains into the result register whenever the
    // result register is empty or its beat is being taken, so a new beat
    // can enter in the same cycle as the held one moves on.
    // ------------------------------------------------------------------
    logic                           in_valid_reg;
    tsrgb_pkg::cmd_t                in_cmd_reg;
    logic [tsrgb_pkg::SAMPLE_W-1:0] in_sample_reg;
    logic                           m_valid_reg;
    logic                           advance;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg    <= tsrgb_pkg::cmd_t'(s_cmd);
            in_sample_reg <= s_sample;
        end
    end

    // ------------------------------------------------------------------
    // Scan and fade state. It is updated when the held beat advances, so
    // beats are applied strictly in order, one per clock while not stalled.
    // ------------------------------------------------------------------
    logic [tsrgb_pkg::PAD_W-1:0]  pad_ptr_reg, pad_ptr_next;
    logic [NP-1:0]                touched_reg, touched_next;
    logic [DUTY_WIDTH-1:0]        duty_reg  [NP];
    logic [DUTY_WIDTH-1:0]        duty_next [NP];
    tsrgb_pkg::chan_ctl_t         ctl_reg   [NP];
    tsrgb_pkg::chan_ctl_t         ctl_next  [NP];

    logic                         is_tick;
    tsrgb_pkg::chan_ctl_t         ctl_sel   [NP];
    tsrgb_pkg::chan_ctl_t         ctl_faded [NP];
    logic [DUTY_WIDTH-1:0]        duty_faded[NP];

    assign is_tick = (in_cmd_reg == tsrgb_pkg::CMD_TICK);

    // Sample path: credit the reading to the current pad and move on.
    always_comb begin
        touched_next = touched_reg;
        pad_ptr_next = pad_ptr_reg;
        if (!is_tick) begin
            if (in_sample_reg != '0) begin
                touched_next[pad_ptr_reg] = (in_sample_reg <= threshold_reg);
            end
            pad_ptr_next = (pad_ptr_reg == tsrgb_pkg::LAST_PAD) ?
                           tsrgb_pkg::FIRST_PAD :
                           pad_ptr_reg + tsrgb_pkg::PAD_W'(1);
        end
    end

    // Direction select: each touched pad, in pad order, sends every
    // channel falling and toggles its own channel, so the highest touched
    // pad decides. With no pad touched the directions are kept.
    always_comb begin
        for (int i = 0; i < NP; i++) begin
            ctl_sel[i] = ctl_reg[i];
        end
        for (int i = 0; i < NP; i++) begin
            if (touched_reg[i]) begin
                for (int j = 0; j < NP; j++) begin
                    ctl_sel[j].dir = tsrgb_pkg::DIR_DOWN;
                end
                ctl_sel[i].dir = ctl_reg[i].on ? tsrgb_pkg::DIR_DOWN : tsrgb_pkg::DIR_UP;
            end
        end
    end

    for (genvar c = 0; c < NP; c++) begin : g_chan
        tsrgb_fade_chan #(
            .DUTY_WIDTH (DUTY_WIDTH)
        ) u_fade (
            .duty_in  (duty_reg[c]),
            .ctl_in   (ctl_sel[c]),
            .duty_out (duty_faded[c]),
            .ctl_out  (ctl_faded[c])
        );
    end

    // Sample beats leave duties, directions and on marks untouched.
    always_comb begin
        for (int c = 0; c < NP; c++) begin
            duty_next[c] = is_tick ? duty_faded[c] : duty_reg[c];
            ctl_next[c]  = is_tick ? ctl_faded[c]  : ctl_reg[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_ptr_reg <= tsrgb_pkg::FIRST_PAD;
            touched_reg <= '0;
            for (int c = 0; c < NP; c++) begin
                duty_reg[c]    <= '0;
                ctl_reg[c].dir <= tsrgb_pkg::DIR_NONE;
                ctl_reg[c].on  <= 1'b0;
            end
        end else if (advance) begin
            pad_ptr_reg <= pad_ptr_next;
            touched_reg <= touched_next;
            for (int c = 0; c < NP; c++) begin
                duty_reg[c] <= duty_next[c];
                ctl_reg[c]  <= ctl_next[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register: a snapshot of the state after the beat.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_touch_flags <= touched_next;
            m_scanned_pad <= pad_ptr_next;
            m_green_duty  <= duty_next[0];
            m_red_duty    <= duty_next[1];
            m_blue_duty   <= duty_next[2];
            for (int c = 0; c < NP; c++) begin
                m_on_flags[c] <= ctl_next[c].on;
            end
        end
    end

    assign m_valid = m_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pad_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pad_ptr_reg != 2'd3)
        else $error("pad pointer left the pad range");

    a_duty_below_top: assert property (@(posedge aclk) disable iff (!aresetn)
        duty_reg[0] != '1 && duty_reg[1] != '1 && duty_reg[2] != '1)
        else $error("a duty reached full scale");

    a_tick_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_tick |=> duty_reg[0] != '0 && duty_reg[1] != '0 && duty_reg[2] != '0)
        else $error("a duty sits at zero after a tick");

    a_sample_keeps_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !is_tick |=>
            $stable(duty_reg[0]) && $stable(duty_reg[1]) && $stable(duty_reg[2]))
        else $error("a sample beat changed a duty");

    a_drain_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stalled with an empty input register");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    import tsrgb_pkg::*;

    // The block is tested at its default duty width. A full-range fade is
    // 65535 ticks long, far more than one run sends, so the duties are
    // checked over the low part of their range plus the clamps at the floor.
    localparam int DUTY_W         = 16;
    localparam int RESULT_LATENCY = 2;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int BURST_TICKS    = 200;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_REPORTS    = 10;
    localparam int IDLE_PERCENT   = 37;

    localparam logic [DUTY_W-1:0] DUTY_TOP = '1;

    typedef struct packed {
        logic [2:0]        touch_flags;
        logic [1:0]        scanned_pad;
        logic [DUTY_W-1:0] green_duty;
        logic [DUTY_W-1:0] red_duty;
        logic [DUTY_W-1:0] blue_duty;
        logic [2:0]        on_flags;
    } fader_beat_t;

    // Clock, reset and ports. Every input starts at a known value.
    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [15:0]         cfg_data  = '0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic                s_cmd     = CMD_SAMPLE;
    logic [SAMPLE_W-1:0] s_sample  = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic [2:0]          m_touch_flags;
    logic [1:0]          m_scanned_pad;
    logic [DUTY_W-1:0]   m_green_duty;
    logic [DUTY_W-1:0]   m_red_duty;
    logic [DUTY_W-1:0]   m_blue_duty;
    logic [2:0]          m_on_flags;

    // Shadow of the block's state, advanced once per accepted input beat.
    logic [15:0]         threshold = '0;
    logic [1:0]          pad_ptr   = FIRST_PAD;
    logic [2:0]          touched   = '0;
    logic [2:0]          lit       = '0;
    logic [DUTY_W-1:0]   duty [NUM_PADS] = '{default: '0};
    fade_dir_t           fade [NUM_PADS] = '{default: DIR_NONE};

    // Result beats predicted but not yet seen on the output, oldest first.
    fader_beat_t         fader_expect[$];
    fader_beat_t         want_beat;

    // Traffic shaping. The steady flags switch off random idling on one
    // side; holding_off is owned by the hold-off process below.
    bit                  sender_steady   = 1'b0;
    bit                  receiver_steady = 1'b0;
    logic                holding_off     = 1'b0;
    event                holdoff_go;

    int                  cycle_count     = 0;
    int                  error_count     = 0;
    int                  items_sent      = 0;
    int                  results_seen    = 0;
    int                  threshold_writes = 0;
    int                  full_marks      = 0;

    touch_scan_rgb_fader #(
        .DUTY_WIDTH(DUTY_W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_touch_flags (m_touch_flags),
        .m_scanned_pad (m_scanned_pad),
        .m_green_duty  (m_green_duty),
        .m_red_duty    (m_red_duty),
        .m_blue_duty   (m_blue_duty),
        .m_on_flags    (m_on_flags)
    );

    // 20 ns clock period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Run-away guard. A correct run finishes far below this limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d result beats outstanding.",
                     cycle_count, fader_expect.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $time, msg);
    endfunction

    function automatic void compare_field(input string field, input logic [15:0] want,
                                          input logic [15:0] got);
        if (want !== got)
            flag_error($sformatf("result beat %0d, %s: expected 0x%0h, got 0x%0h",
                                 results_seen, field, want, got));
    endfunction

    // Advances the shadow state by one input beat and queues the result
    // beat that the block must produce for it.
    function automatic void step_fader(input cmd_t cmd, input logic [SAMPLE_W-1:0] sample);
        logic [DUTY_W-1:0] level;
        fader_beat_t       beat;
        if (cmd == CMD_SAMPLE) begin
            // A zero reading leaves the pad alone, but the scan still moves on.
            if (sample != '0)
                touched[pad_ptr] = (sample <= threshold);
            pad_ptr = (pad_ptr == LAST_PAD) ? FIRST_PAD : pad_ptr + 1'b1;
        end else begin
            // Pads are visited in order, so the highest touched pad wins.
            for (int p = 0; p < NUM_PADS; p++) begin
                if (touched[p]) begin
                    for (int c = 0; c < NUM_PADS; c++)
                        fade[c] = DIR_DOWN;
                    fade[p] = lit[p] ? DIR_DOWN : DIR_UP;
                end
            end
            for (int c = 0; c < NUM_PADS; c++) begin
                level = duty[c];
                // Both steps saturate: falling from zero holds at zero.
                if (fade[c] == DIR_UP && level != DUTY_TOP)
                    level = level + 1'b1;
                else if (fade[c] == DIR_DOWN && level != '0)
                    level = level - 1'b1;
                if (level == DUTY_TOP) begin
                    level = DUTY_TOP - 1'b1;
                    if (!lit[c])
                        full_marks++;
                    lit[c]  = 1'b1;
                    fade[c] = DIR_NONE;
                end
                if (level == '0) begin
                    level   = DUTY_W'(1);
                    lit[c]  = 1'b0;
                    fade[c] = DIR_NONE;
                end
                duty[c] = level;
            end
        end
        beat.touch_flags = touched;
        beat.scanned_pad = pad_ptr;
        beat.green_duty  = duty[0];
        beat.red_duty    = duty[1];
        beat.blue_duty   = duty[2];
        beat.on_flags    = lit;
        fader_expect.push_back(beat);
    endfunction

    // Receiver. It stalls at random unless told to stay ready, and the
    // hold-off window overrides everything else.
    always @(negedge aclk) begin
        if (holding_off) begin
            m_ready <= 1'b0;
        end else if (receiver_steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Long output stall, counted here so that the sender keeps running
    // into a full pipeline while the window is open.
    always begin
        @(holdoff_go);
        @(negedge aclk);
        holding_off <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(negedge aclk);
        holding_off <= 1'b0;
    end

    // Result checker: every accepted result beat is matched against the
    // oldest prediction, field by field.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (fader_expect.size() == 0) begin
                flag_error($sformatf("result beat %0d arrived with nothing expected",
                                     results_seen));
            end else begin
                want_beat = fader_expect.pop_front();
                compare_field("touch_flags", 16'(want_beat.touch_flags), 16'(m_touch_flags));
                compare_field("scanned_pad", 16'(want_beat.scanned_pad), 16'(m_scanned_pad));
                compare_field("green_duty",  16'(want_beat.green_duty),  16'(m_green_duty));
                compare_field("red_duty",    16'(want_beat.red_duty),    16'(m_red_duty));
                compare_field("blue_duty",   16'(want_beat.blue_duty),   16'(m_blue_duty));
                compare_field("on_flags",    16'(want_beat.on_flags),    16'(m_on_flags));
            end
            results_seen++;
        end
    end

    // Offers one input beat and holds it until accepted. Afterwards the
    // sender may go quiet for a few cycles. Every exit is just past a
    // rising edge, so flags changed by the caller never race the negedge
    // drivers.
    task automatic send_beat(input cmd_t cmd, input logic [SAMPLE_W-1:0] sample);
        @(negedge aclk);
        s_valid  <= 1'b1;
        s_cmd    <= cmd;
        s_sample <= sample;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        step_fader(cmd, sample);
        items_sent++;
        if (!sender_steady && $urandom_range(99) < IDLE_PERCENT) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            @(posedge aclk);
            repeat ($urandom_range(3))
                @(posedge aclk);
        end
    endtask

    // Stops offering beats and waits until every predicted result is out,
    // plus enough cycles for the pipeline to empty.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (fader_expect.size() != 0)
            @(posedge aclk);
        repeat (RESULT_LATENCY + 2)
            @(posedge aclk);
    endtask

    // Only called while nothing is in flight.
    task automatic write_threshold(input logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        threshold = value;
        threshold_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Readings cluster around the threshold and the ends of the range, so
    // that both sides of the touch compare show up often.
    function automatic logic [SAMPLE_W-1:0] pick_reading();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 16'h0001;
            3: return threshold;
            4: return threshold + 1'b1;
            5: return threshold - 1'b1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Hand-picked beats: boundaries of the touch compare, the zero reading,
    // falling from zero on the very first tick, pad priority, and the
    // threshold at both ends of its range.
    task automatic test_directed_corners();
        write_threshold(16'h8000);
        send_beat(CMD_SAMPLE, 16'h8000);   // Pad 0 equals the threshold: touched.
        send_beat(CMD_SAMPLE, 16'h8001);   // Pad 1 is one above: not touched.
        send_beat(CMD_SAMPLE, 16'h0000);   // Pad 2 gets no reading.
        // Red and blue are told to fall while still at zero after reset.
        send_beat(CMD_TICK,   16'h0000);
        send_beat(CMD_TICK,   16'hFFFF);
        send_beat(CMD_SAMPLE, 16'h0000);   // Pad 0 keeps its touch.
        send_beat(CMD_SAMPLE, 16'h0001);   // Pad 1 touched with the smallest reading.
        send_beat(CMD_SAMPLE, 16'hFFFF);   // Pad 2 not touched.
        send_beat(CMD_TICK,   16'h5A5A);   // Pad 1 overrides pad 0.
        send_beat(CMD_TICK,   16'hA5A5);
        drain_results();

        write_threshold(16'hFFFF);
        send_beat(CMD_SAMPLE, 16'hFFFF);
        send_beat(CMD_SAMPLE, 16'h7FFF);
        send_beat(CMD_SAMPLE, 16'h8000);
        send_beat(CMD_TICK,   16'h0001);   // All pads touched; blue wins.
        send_beat(CMD_TICK,   16'h8000);
        drain_results();

        write_threshold(16'h0000);
        send_beat(CMD_SAMPLE, 16'h0001);   // Nothing can touch now.
        send_beat(CMD_SAMPLE, 16'hFFFF);
        send_beat(CMD_SAMPLE, 16'h0000);   // Pad 2 keeps the touch it had.
        send_beat(CMD_TICK,   16'h1234);
        send_beat(CMD_TICK,   16'hEDCB);
        drain_results();
    endtask

    // Holds pad 0 touched and ticks a long burst, so green climbs while red
    // and blue sit on the floor. Neither side idles, so this is also the
    // long back-to-back stretch of the run.
    task automatic test_back_to_back();
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        write_threshold(16'h8000);
        repeat (NUM_PADS)
            send_beat(CMD_SAMPLE, (pad_ptr == FIRST_PAD) ? 16'h0001 : 16'hFFFF);
        repeat (BURST_TICKS)
            send_beat(CMD_TICK, SAMPLE_W'($urandom));
        drain_results();
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // Mostly well-formed traffic: full scan sweeps followed by ticks, with
    // tick bursts long enough to move the duties, some arbitrary beats, and
    // now and then a pause until every result is back.
    task automatic test_random_scan(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(19);
            if (pick < 12) begin
                repeat (NUM_PADS)
                    send_beat(CMD_SAMPLE, pick_reading());
                repeat ($urandom_range(1, 6))
                    send_beat(CMD_TICK, SAMPLE_W'($urandom));
            end else if (pick < 16) begin
                repeat ($urandom_range(1, 20))
                    send_beat(CMD_TICK, SAMPLE_W'($urandom));
            end else if (pick < 19) begin
                repeat ($urandom_range(1, 8))
                    send_beat(cmd_t'($urandom_range(1)), SAMPLE_W'($urandom));
            end else begin
                drain_results();
            end
        end
    endtask

    // The output stalls for a long window while the sender keeps offering
    // beats back to back, so the block fills and must drop s_ready.
    task automatic test_output_stall();
        sender_steady = 1'b1;
        -> holdoff_go;
        repeat (60)
            send_beat(cmd_t'($urandom_range(1)), pick_reading());
        sender_steady = 1'b0;
        drain_results();
    endtask

    initial begin
        logic [15:0] phase_thresholds [5];
        phase_thresholds = '{16'h8000, 16'hFFFF, 16'h0000,
                             16'($urandom), 16'($urandom)};

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_corners();
        test_back_to_back();
        foreach (phase_thresholds[i]) begin
            drain_results();
            write_threshold(phase_thresholds[i]);
            test_random_scan(350);
        end
        test_output_stall();

        drain_results();

        $display("Sent %0d input beats, checked %0d result beats, %0d threshold writes.",
                 items_sent, results_seen, threshold_writes);
        $display("Channels reached full brightness %0d times; %0d mismatches in total.",
                 full_marks, error_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
